// ===== hw/rtl/acr_pkg.sv =====
// Shared codes, reset values, decode tables and types for the audio controller config block.
`timescale 1ns / 1ps

package acr_pkg;

    // Access kinds and targets
    localparam logic OP_READ    = 1'b0;
    localparam logic OP_WRITE   = 1'b1;
    localparam logic TGT_WINDOW = 1'b0;
    localparam logic TGT_CODEC  = 1'b1;

    // Window offsets
    localparam logic [2:0] OFF_MC1  = 3'd0;
    localparam logic [2:0] OFF_MC2  = 3'd1;
    localparam logic [2:0] OFF_MC3  = 3'd2;
    localparam logic [2:0] OFF_MC4  = 3'd3;
    localparam logic [2:0] OFF_MC5  = 3'd4;
    localparam logic [2:0] OFF_MC6  = 3'd5;
    localparam logic [2:0] OFF_PASS = OFF_MC3;

    localparam int MC_COUNT = 6;
    localparam logic [7:0] MC_RESET [MC_COUNT] =
        '{8'h00, 8'h03, 8'h00, 8'h00, 8'h3F, 8'h83};

    localparam logic [7:0] CHIP_ID_RESET = 8'hE3;
    localparam logic [7:0] READ_IDLE     = 8'hFF;
    localparam logic [7:0] MC3_FORCED    = 8'h02;
    localparam logic [7:0] MC3_READ_MASK = 8'hFC;
    localparam logic [7:0] MC3_READ_SET  = 8'h02;
    localparam logic [7:0] CODEC_STATUS  = 8'h04;
    localparam logic [7:0] CODEC_FLAG    = 8'h40;

    // Password sequence phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_THIRD  = 2'd3;

    // Compatibility decode
    localparam logic [9:0] COMPAT_BASE_LO    = 10'h220;
    localparam logic [9:0] COMPAT_BASE_HI    = 10'h240;
    localparam logic [3:0] COMPAT_IRQ_RESET  = 4'd5;
    localparam logic [1:0] COMPAT_DMA_RESET  = 2'd1;
    localparam logic [3:0] COMPAT_IRQ_MAP [4] = '{4'd7, 4'd10, 4'd5, 4'd5};
    localparam logic [1:0] COMPAT_DMA_MAP [4] = '{2'd1, 2'd0, 2'd3, 2'd3};

    // Codec port and fixed decode tables
    localparam logic [1:0]  CODEC_DMA_MAP  [4] = '{2'd0, 2'd0, 2'd1, 2'd3};
    localparam logic [3:0]  CODEC_IRQ_MAP  [8] =
        '{4'd5, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd14, 4'd15};
    localparam logic [11:0] CODEC_BASE_MAP [4] = '{12'h530, 12'hE80, 12'hF40, 12'h604};
    localparam logic [9:0]  MIDI_BASE_MAP  [4] = '{10'h330, 10'h320, 10'h310, 10'h300};
    localparam logic [3:0]  MIDI_IRQ_MAP   [4] = '{4'd9, 4'd10, 4'd5, 4'd7};

    typedef struct packed {
        logic        codec_mode;
        logic [11:0] codec_base;
        logic [9:0]  midi_base;
        logic [3:0]  midi_irq;
        logic        joystick_enabled;
        logic        output_muted;
    } acr_dec_t;

    typedef struct packed {
        logic [7:0]  read_data;
        acr_dec_t    dec;
        logic [9:0]  compat_base;
        logic [3:0]  compat_irq;
        logic [1:0]  compat_dma;
        logic [3:0]  codec_irq;
        logic [1:0]  codec_dma;
    } acr_res_t;

endpackage

// ===== hw/rtl/acr_if.sv =====
// Valid/ready channel interfaces for access requests and results.
`timescale 1ns / 1ps

interface acr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic       target;
    logic [2:0] register_offset;
    logic [7:0] write_data;

    modport source (output valid, output opcode, output target,
                    output register_offset, output write_data, input ready);
    modport sink   (input valid, input opcode, input target,
                    input register_offset, input write_data, output ready);
endinterface

interface acr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        codec_mode;
    logic [11:0] codec_base;
    logic [9:0]  compat_base;
    logic [3:0]  compat_irq;
    logic [1:0]  compat_dma;
    logic [9:0]  midi_base;
    logic [3:0]  midi_irq;
    logic [3:0]  codec_irq;
    logic [1:0]  codec_dma;
    logic        joystick_enabled;
    logic        output_muted;

    modport source (output valid, output read_data, output codec_mode, output codec_base,
                    output compat_base, output compat_irq, output compat_dma,
                    output midi_base, output midi_irq, output codec_irq, output codec_dma,
                    output joystick_enabled, output output_muted, input ready);
    modport sink   (input valid, input read_data, input codec_mode, input codec_base,
                    input compat_base, input compat_irq, input compat_dma,
                    input midi_base, input midi_irq, input codec_irq, input codec_dma,
                    input joystick_enabled, input output_muted, output ready);
endinterface

// ===== hw/rtl/acr_decode.sv =====
// Decode of stored MC1, MC4 and MC6 fields into codec, MIDI, game port and mute settings.
`timescale 1ns / 1ps

module acr_decode
    import acr_pkg::*;
(
    input  logic [7:0] mc1,
    input  logic [7:0] mc4,
    input  logic [7:0] mc6,
    output acr_dec_t   dec
);

    always_comb
    begin
        dec.codec_mode       = mc1[7];
        dec.codec_base       = CODEC_BASE_MAP[mc1[5:4]];
        dec.midi_base        = MIDI_BASE_MAP[mc6[6:5]];
        dec.midi_irq         = MIDI_IRQ_MAP[mc6[4:3]];
        dec.joystick_enabled = ~mc1[0];
        dec.output_muted     = mc4[2];
    end

endmodule

// ===== hw/rtl/audio_controller_config_regs.sv =====
// Top level of the audio controller configuration block: register window, codec port, decode.
`timescale 1ns / 1ps

// Usage:
//   in_ch  carries one bus access per transfer: opcode (read/write), target (window or
//          codec config port), register_offset and write_data.
//   out_ch returns exactly one result per access: the byte read (0 on writes, 0xFF when
//          locked or gated) plus every decoded setting as it stands after the access.
//   cfg_wr_en / cfg_wr_data load the chip id byte used as unlock password; write it only
//          while no access is in flight.
// The result of an accepted access is registered and offered in the cycle after it is accepted.
// Throughput is one access per cycle while results are taken; the single result register sets that figure, and
// in_ch.ready stays high while that register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and in_ch.ready drops until it is taken.
// Reset (rst_n low, asynchronous) loads MC1..MC6 with 00,03,00,00,3F,83 hex, locks the
// window, clears the password sequence and codec settings, sets the compatibility decode
// to base 0x220, IRQ 5, DMA 1, and restores chip id 0xE3. No clearing pass is needed.
// Each window access consumes the unlock; writing chip id to MC3 grants the next one.
module audio_controller_config_regs
    import acr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    acr_in_if.sink     in_ch,
    acr_out_if.source  out_ch
);

    // Architectural state
    logic [7:0] mc_bank_reg [MC_COUNT];
    logic [7:0] mc_bank_next [MC_COUNT];
    logic       unlocked_reg, unlocked_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] codec_setting_reg, codec_setting_next;
    logic [9:0] compat_base_reg, compat_base_next;
    logic [3:0] compat_irq_reg, compat_irq_next;
    logic [1:0] compat_dma_reg, compat_dma_next;
    logic [3:0] codec_irq_reg, codec_irq_next;
    logic [1:0] codec_dma_reg, codec_dma_next;
    logic [7:0] chip_id_reg;

    // Result stage
    logic       out_valid_reg, out_valid_next;
    acr_res_t   res_reg, res_next;
    acr_dec_t   dec;
    logic       accept;
    logic [7:0] read_byte;

    // Advance whenever the result register is empty or drains this cycle
    assign in_ch.ready = ~out_valid_reg | out_ch.ready;
    assign accept      = in_ch.valid & in_ch.ready;

    // Access handling: compute the state after this access
    always_comb
    begin
        logic       port_open;
        logic       id_match;
        logic       zero_byte;
        logic [2:0] off;
        logic [7:0] v;

        off       = in_ch.register_offset;
        v         = in_ch.write_data;
        id_match  = (v == chip_id_reg);
        zero_byte = (v == 8'h00);
        port_open = mc_bank_reg[OFF_MC5][4] | mc_bank_reg[OFF_MC1][7];

        for (int i = 0; i < MC_COUNT; i++)
        begin
            mc_bank_next[i] = mc_bank_reg[i];
        end
        unlocked_next      = unlocked_reg;
        phase_next         = phase_reg;
        codec_setting_next = codec_setting_reg;
        compat_base_next   = compat_base_reg;
        compat_irq_next    = compat_irq_reg;
        compat_dma_next    = compat_dma_reg;
        codec_irq_next     = codec_irq_reg;
        codec_dma_next     = codec_dma_reg;
        read_byte          = 8'h00;

        if (in_ch.target == TGT_WINDOW)
        begin
            unlocked_next = 1'b0;
            if (in_ch.opcode == OP_WRITE)
            begin
                // Store through an open window; MC3 skips the password byte
                if (unlocked_reg && off <= OFF_MC6)
                begin
                    if (off == OFF_MC3)
                    begin
                        if (!id_match)
                        begin
                            mc_bank_next[OFF_MC3] = v;
                            if (mc_bank_reg[OFF_MC3] != v)
                            begin
                                compat_base_next = v[2] ? COMPAT_BASE_HI : COMPAT_BASE_LO;
                                compat_dma_next  = COMPAT_DMA_MAP[v[5:4]];
                                compat_irq_next  = COMPAT_IRQ_MAP[v[7:6]];
                            end
                        end
                    end
                    else
                    begin
                        mc_bank_next[off] = v;
                    end
                end
                // Unlock and password sequence
                if (off == OFF_PASS && (id_match || zero_byte))
                begin
                    if (id_match)
                    begin
                        unlocked_next = 1'b1;
                    end
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            phase_next = PH_FIRST;
                        end
                        PH_FIRST:
                        begin
                            if (id_match)
                            begin
                                phase_next = PH_SECOND;
                            end
                        end
                        PH_SECOND:
                        begin
                            if (zero_byte)
                            begin
                                phase_next = PH_THIRD;
                            end
                        end
                        default:
                        begin
                            if (id_match)
                            begin
                                mc_bank_next[OFF_MC3] = MC3_FORCED;
                                phase_next            = PH_FIRST;
                            end
                        end
                    endcase
                end
            end
            else
            begin
                read_byte = READ_IDLE;
                if (unlocked_reg)
                begin
                    unique case (off) inside
                        OFF_MC1, OFF_MC2, OFF_MC4, OFF_MC5, OFF_MC6:
                        begin
                            read_byte = mc_bank_reg[off];
                        end
                        OFF_MC3:
                        begin
                            read_byte = (mc_bank_reg[OFF_MC3] & MC3_READ_MASK) | MC3_READ_SET;
                        end
                        default:
                        begin
                            read_byte = READ_IDLE;
                        end
                    endcase
                end
            end
        end
        else
        begin
            // Codec config port, gated by MC5 bit 4 or codec mode; leave the unlock alone
            if (in_ch.opcode == OP_WRITE)
            begin
                if (port_open)
                begin
                    codec_setting_next = v;
                    codec_dma_next     = CODEC_DMA_MAP[v[1:0]];
                    codec_irq_next     = CODEC_IRQ_MAP[v[5:3]];
                end
            end
            else
            begin
                read_byte = port_open ? (CODEC_STATUS | (codec_setting_reg & CODEC_FLAG))
                                      : READ_IDLE;
            end
        end
    end

    // Decode the settings as they stand after the access
    acr_decode u_decode (
        .mc1 (mc_bank_next[OFF_MC1]),
        .mc4 (mc_bank_next[OFF_MC4]),
        .mc6 (mc_bank_next[OFF_MC6]),
        .dec (dec)
    );

    always_comb
    begin
        res_next.read_data   = read_byte;
        res_next.dec         = dec;
        res_next.compat_base = compat_base_next;
        res_next.compat_irq  = compat_irq_next;
        res_next.compat_dma  = compat_dma_next;
        res_next.codec_irq   = codec_irq_next;
        res_next.codec_dma   = codec_dma_next;
        out_valid_next       = accept | (out_valid_reg & ~out_ch.ready);
    end

    // State update: commit only on an accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MC_COUNT; i++)
            begin
                mc_bank_reg[i] <= MC_RESET[i];
            end
            unlocked_reg      <= 1'b0;
            phase_reg         <= PH_IDLE;
            codec_setting_reg <= 8'h00;
            compat_base_reg   <= COMPAT_BASE_LO;
            compat_irq_reg    <= COMPAT_IRQ_RESET;
            compat_dma_reg    <= COMPAT_DMA_RESET;
            codec_irq_reg     <= 4'd0;
            codec_dma_reg     <= 2'd0;
            chip_id_reg       <= CHIP_ID_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                chip_id_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                for (int i = 0; i < MC_COUNT; i++)
                begin
                    mc_bank_reg[i] <= mc_bank_next[i];
                end
                unlocked_reg      <= unlocked_next;
                phase_reg         <= phase_next;
                codec_setting_reg <= codec_setting_next;
                compat_base_reg   <= compat_base_next;
                compat_irq_reg    <= compat_irq_next;
                compat_dma_reg    <= compat_dma_next;
                codec_irq_reg     <= codec_irq_next;
                codec_dma_reg     <= codec_dma_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.read_data        = res_reg.read_data;
    assign out_ch.codec_mode       = res_reg.dec.codec_mode;
    assign out_ch.codec_base       = res_reg.dec.codec_base;
    assign out_ch.compat_base      = res_reg.compat_base;
    assign out_ch.compat_irq       = res_reg.compat_irq;
    assign out_ch.compat_dma       = res_reg.compat_dma;
    assign out_ch.midi_base        = res_reg.dec.midi_base;
    assign out_ch.midi_irq         = res_reg.dec.midi_irq;
    assign out_ch.codec_irq        = res_reg.codec_irq;
    assign out_ch.codec_dma        = res_reg.codec_dma;
    assign out_ch.joystick_enabled = res_reg.dec.joystick_enabled;
    assign out_ch.output_muted     = res_reg.dec.output_muted;

endmodule

// ===== hw/rtl/acr_checker.sv =====
// Port-level checks for the audio controller config block, bound to the top level.
`timescale 1ns / 1ps

module acr_checker
    import acr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_read_data
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Every accepted access yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted access produced no result");

    // No new access is taken while a result waits undelivered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("access accepted over a pending result");

    // Write accesses return a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_opcode == OP_WRITE |=> out_read_data == 8'h00)
        else $error("write access returned nonzero read data");

endmodule

bind audio_controller_config_regs acr_checker u_acr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_opcode     (in_ch.opcode),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_read_data (out_ch.read_data)
);

// ===== tb/sv/acr_tb_pkg.sv =====
// Shadow copy of the config block state and the checker for its access results.
`timescale 1ns / 1ps

package acr_tb_pkg;
    import acr_pkg::*;

    class acr_access_board;
        logic [7:0] chip_id;
        logic [7:0] mc_shadow [MC_COUNT];
        bit         win_open;
        logic [1:0] pass_phase;
        logic [7:0] codec_setting;
        logic [9:0] compat_base;
        logic [3:0] compat_irq;
        logic [1:0] compat_dma;
        logic [3:0] codec_irq;
        logic [1:0] codec_dma;
        acr_res_t   pending_results [$];
        int         mismatches;

        function new();
            chip_id = CHIP_ID_RESET;
            foreach (mc_shadow[i])
                mc_shadow[i] = MC_RESET[i];
            win_open      = 1'b0;
            pass_phase    = PH_IDLE;
            codec_setting = 8'h00;
            compat_base   = COMPAT_BASE_LO;
            compat_irq    = COMPAT_IRQ_RESET;
            compat_dma    = COMPAT_DMA_RESET;
            codec_irq     = 4'd0;
            codec_dma     = 2'd0;
            mismatches    = 0;
        endfunction

        function void set_chip_id(logic [7:0] v);
            chip_id = v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Advance the shadow state by one accepted access and queue the settings it leaves.
        function void note_access(logic op, logic tgt, logic [2:0] off, logic [7:0] v);
            acr_res_t   r;
            logic [7:0] rd;
            bit         port_open;
            rd = 8'h00;
            port_open = mc_shadow[OFF_MC5][4] || mc_shadow[OFF_MC1][7];

            if (tgt == TGT_WINDOW && op == OP_WRITE)
            begin
                if (win_open && off < MC_COUNT)
                begin
                    if (off == OFF_MC3)
                    begin
                        // chip id is never stored; decode only on a real change
                        if (v != chip_id)
                        begin
                            if (mc_shadow[OFF_MC3] != v)
                            begin
                                compat_base = v[2] ? COMPAT_BASE_HI : COMPAT_BASE_LO;
                                case (v[5:4])
                                    2'd0:    compat_dma = 2'd1;
                                    2'd1:    compat_dma = 2'd0;
                                    default: compat_dma = 2'd3;
                                endcase
                                case (v[7:6])
                                    2'd0:    compat_irq = 4'd7;
                                    2'd1:    compat_irq = 4'd10;
                                    default: compat_irq = 4'd5;
                                endcase
                            end
                            mc_shadow[OFF_MC3] = v;
                        end
                    end
                    else
                        mc_shadow[off] = v;
                end
                win_open = 1'b0;
                if (off == OFF_PASS && (v == chip_id || v == 8'h00))
                begin
                    if (v == chip_id)
                        win_open = 1'b1;
                    case (pass_phase)
                        PH_IDLE:   pass_phase = PH_FIRST;
                        PH_FIRST:  if (v == chip_id) pass_phase = PH_SECOND;
                        PH_SECOND: if (v == 8'h00) pass_phase = PH_THIRD;
                        default:
                            if (v == chip_id)
                            begin
                                mc_shadow[OFF_MC3] = MC3_FORCED;
                                pass_phase = PH_FIRST;
                            end
                    endcase
                end
            end
            else if (tgt == TGT_WINDOW)
            begin
                rd = READ_IDLE;
                if (win_open)
                begin
                    if (off == OFF_MC3)
                        rd = (mc_shadow[OFF_MC3] & MC3_READ_MASK) | MC3_READ_SET;
                    else if (off < MC_COUNT)
                        rd = mc_shadow[off];
                    win_open = 1'b0;
                end
            end
            else if (op == OP_WRITE)
            begin
                if (port_open)
                begin
                    codec_setting = v;
                    case (v[1:0])
                        2'd2:    codec_dma = 2'd1;
                        2'd3:    codec_dma = 2'd3;
                        default: codec_dma = 2'd0;
                    endcase
                    case (v[5:3])
                        3'd0:    codec_irq = 4'd5;
                        3'd1:    codec_irq = 4'd7;
                        3'd2:    codec_irq = 4'd9;
                        3'd3:    codec_irq = 4'd10;
                        3'd4:    codec_irq = 4'd11;
                        3'd5:    codec_irq = 4'd12;
                        3'd6:    codec_irq = 4'd14;
                        default: codec_irq = 4'd15;
                    endcase
                end
            end
            else
                rd = port_open ? (CODEC_STATUS | (codec_setting & CODEC_FLAG)) : READ_IDLE;

            r.read_data = rd;
            r.dec.codec_mode = mc_shadow[OFF_MC1][7];
            case (mc_shadow[OFF_MC1][5:4])
                2'd0:    r.dec.codec_base = 12'h530;
                2'd1:    r.dec.codec_base = 12'hE80;
                2'd2:    r.dec.codec_base = 12'hF40;
                default: r.dec.codec_base = 12'h604;
            endcase
            // MIDI base steps down by 0x10 per code
            r.dec.midi_base = 10'h330 - {4'h0, mc_shadow[OFF_MC6][6:5], 4'h0};
            case (mc_shadow[OFF_MC6][4:3])
                2'd0:    r.dec.midi_irq = 4'd9;
                2'd1:    r.dec.midi_irq = 4'd10;
                2'd2:    r.dec.midi_irq = 4'd5;
                default: r.dec.midi_irq = 4'd7;
            endcase
            r.dec.joystick_enabled = ~mc_shadow[OFF_MC1][0];
            r.dec.output_muted     = mc_shadow[OFF_MC4][2];
            r.compat_base = compat_base;
            r.compat_irq  = compat_irq;
            r.compat_dma  = compat_dma;
            r.codec_irq   = codec_irq;
            r.codec_dma   = codec_dma;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string fname, logic [11:0] want, logic [11:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %0h, got %0h", fname, want, got);
            end
        endfunction

        function void check_result(acr_res_t got);
            acr_res_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no access pending: read_data %0h", got.read_data);
                return;
            end
            want = pending_results.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("codec_mode", want.dec.codec_mode, got.dec.codec_mode);
            compare_field("codec_base", want.dec.codec_base, got.dec.codec_base);
            compare_field("compat_base", want.compat_base, got.compat_base);
            compare_field("compat_irq", want.compat_irq, got.compat_irq);
            compare_field("compat_dma", want.compat_dma, got.compat_dma);
            compare_field("midi_base", want.dec.midi_base, got.dec.midi_base);
            compare_field("midi_irq", want.dec.midi_irq, got.dec.midi_irq);
            compare_field("codec_irq", want.codec_irq, got.codec_irq);
            compare_field("codec_dma", want.codec_dma, got.codec_dma);
            compare_field("joystick_enabled", want.dec.joystick_enabled,
                          got.dec.joystick_enabled);
            compare_field("output_muted", want.dec.output_muted, got.dec.output_muted);
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level bench for the audio controller config block: stimulus, handshakes, final verdict.
`timescale 1ns / 1ps

module tb_top;
    import acr_pkg::*;
    import acr_tb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 275;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_ready;
    int cycles = 0;
    int items_sent;

    acr_access_board board;

    acr_in_if  in_ch ();
    acr_out_if out_ch ();

    audio_controller_config_regs uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    always #1 clk = ~clk;

    // Stop a hung run; the limit sits far above the slowest legal run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: drop ready at random, or for the whole of a long hold-off.
    always @(negedge clk)
        out_ch.ready <= !hold_ready && ($urandom_range(99) >= receiver_stall_pct);

    // Sample each result transfer at the rising edge and hand it to the checker.
    always @(posedge clk)
    begin
        acr_res_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.read_data            = out_ch.read_data;
            got.dec.codec_mode       = out_ch.codec_mode;
            got.dec.codec_base       = out_ch.codec_base;
            got.dec.midi_base        = out_ch.midi_base;
            got.dec.midi_irq         = out_ch.midi_irq;
            got.dec.joystick_enabled = out_ch.joystick_enabled;
            got.dec.output_muted     = out_ch.output_muted;
            got.compat_base          = out_ch.compat_base;
            got.compat_irq           = out_ch.compat_irq;
            got.compat_dma           = out_ch.compat_dma;
            got.codec_irq            = out_ch.codec_irq;
            got.codec_dma            = out_ch.codec_dma;
            board.check_result(got);
        end
    end

    // Offer one access, starting at a falling edge; return at the falling edge after
    // its transfer with valid still high, so back-to-back calls keep the bus busy.
    task automatic send_access(input logic op, input logic tgt, input logic [2:0] off,
                               input logic [7:0] data);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid           = 1'b1;
        in_ch.opcode          = op;
        in_ch.target          = tgt;
        in_ch.register_offset = off;
        in_ch.write_data      = data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_access(op, tgt, off, data);
        items_sent++;
        @(negedge clk);
    endtask

    // Grant the window with the chip id, then make the access that consumes it.
    task automatic unlocked_access(input logic op, input logic [2:0] off,
                                   input logic [7:0] data);
        send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, board.chip_id);
        send_access(op, TGT_WINDOW, off, data);
    endtask

    // Hold the sender until every queued result has been transferred.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_chip_id(input logic [7:0] v);
        drain();
        repeat (2) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        board.set_chip_id(v);
    endtask

    // Bias data toward the bytes that steer the password logic.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0, 1:    return board.chip_id;
            2, 3:    return 8'h00;
            4:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed unlock/access pairs and password runs, the rest broken
    // sequences, codec port traffic and raw noise.
    task automatic run_traffic(input int n);
        int         stop;
        int         kind;
        logic [2:0] off;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            kind = $urandom_range(99);
            off  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            if (kind < 50)
                unlocked_access(1'($urandom_range(1)), off, pick_byte());
            else if (kind < 65)
                send_access(1'($urandom_range(1)), TGT_CODEC, 3'($urandom), pick_byte());
            else if (kind < 73)
            begin
                // id / id / zero / id forces MC3; read it back while still unlocked
                send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, board.chip_id);
                send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, board.chip_id);
                send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, 8'h00);
                send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, board.chip_id);
                send_access(OP_READ, TGT_WINDOW, OFF_MC3, 8'($urandom));
            end
            else if (kind < 85)
            begin
                // unlock interrupted by codec traffic or a second password write
                send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, board.chip_id);
                if ($urandom_range(1))
                    send_access(1'($urandom_range(1)), TGT_CODEC, 3'($urandom), 8'($urandom));
                if ($urandom_range(1))
                    send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, pick_byte());
                send_access(1'($urandom_range(1)), TGT_WINDOW, off, pick_byte());
            end
            else
                send_access(1'($urandom_range(1)), 1'($urandom_range(1)), 3'($urandom),
                            8'($urandom));
        end
    endtask

    initial
    begin
        board                 = new();
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 8'h00;
        in_ch.valid           = 1'b0;
        in_ch.opcode          = OP_READ;
        in_ch.target          = TGT_WINDOW;
        in_ch.register_offset = OFF_MC1;
        in_ch.write_data      = 8'h00;
        out_ch.ready          = 1'b0;
        sender_idle_pct       = 0;
        receiver_stall_pct    = 0;
        hold_ready            = 1'b0;
        items_sent            = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pass with the reset chip id.
        send_access(OP_READ, TGT_WINDOW, OFF_MC1, 8'h00);       // locked read
        send_access(OP_WRITE, TGT_WINDOW, OFF_MC2, 8'hFF);      // locked write, dropped
        send_access(OP_WRITE, TGT_CODEC, 3'd0, 8'hFF);          // port open out of reset
        send_access(OP_READ, TGT_CODEC, 3'd0, 8'h00);
        unlocked_access(OP_READ, OFF_MC3, 8'h00);               // low bits read as 10b
        unlocked_access(OP_WRITE, OFF_MC5, 8'h00);              // close the codec port
        send_access(OP_WRITE, TGT_CODEC, 3'd7, 8'h00);          // gated, ignored
        send_access(OP_READ, TGT_CODEC, 3'd7, 8'h00);           // gated read
        unlocked_access(OP_WRITE, OFF_MC1, 8'hB1);              // codec mode reopens port
        unlocked_access(OP_WRITE, OFF_MC3, 8'hF4);              // new compat decode
        unlocked_access(OP_WRITE, OFF_MC3, board.chip_id);      // chip id is not stored
        send_access(OP_WRITE, TGT_WINDOW, 3'd7, 8'h00);         // no register, eats unlock
        unlocked_access(OP_READ, 3'd6, 8'h00);                  // no register
        unlocked_access(OP_WRITE, OFF_MC6, 8'h7F);
        unlocked_access(OP_WRITE, OFF_MC4, 8'hFF);              // mute output
        send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, 8'h00);     // finish the password run
        send_access(OP_WRITE, TGT_WINDOW, OFF_PASS, board.chip_id);
        send_access(OP_READ, TGT_WINDOW, OFF_MC3, 8'h00);       // forced value

        // Back-to-back traffic with the lowest chip id: unlock byte equals the zero step.
        write_chip_id(8'h00);
        run_traffic(PHASE_ITEMS);

        write_chip_id(8'hFF);
        sender_idle_pct = 58;
        run_traffic(PHASE_ITEMS);

        write_chip_id(8'($urandom));
        sender_idle_pct    = 0;
        receiver_stall_pct = 58;
        run_traffic(PHASE_ITEMS);

        write_chip_id(CHIP_ID_RESET);
        sender_idle_pct    = 25;
        receiver_stall_pct = 25;
        run_traffic(PHASE_ITEMS);

        // Hold off the receiver while the sender keeps offering, so the block backs
        // up and drops in_ch.ready; then pause the sender until all results are in.
        write_chip_id(8'($urandom));
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        fork
            begin
                @(posedge clk);
                hold_ready = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_ready = 1'b0;
            end
        join_none
        run_traffic(40);
        drain();
        run_traffic(PHASE_ITEMS - 40);

        drain();
        repeat (4) @(negedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
